// ----- rtl/tts_pkg.sv -----
// Shared types and constants of the task timing statistics unit.
package tts_pkg;

    localparam int TIME_BITS   = 48;
    localparam int NUM_TASKS   = 5;
    localparam int TASK_BITS   = 3;
    localparam int DL_BITS     = 24;
    localparam int CNT_BITS    = 32;
    localparam int SUM_BITS    = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // Deadline reset values, task 4 in the top slice.
    localparam logic [NUM_TASKS-1:0][DL_BITS-1:0] DEADLINE_RESET = {
        24'd5000, 24'd5000, 24'd10000, 24'd10000, 24'd5000
    };

    // Classified word handed from the front end to the update stage.
    typedef struct packed {
        logic [TASK_BITS-1:0]        task_id;
        logic [TIME_BITS-1:0]        latency;
        logic signed [TIME_BITS:0]   exec_time;
        logic signed [TIME_BITS:0]   total_time;
        logic                        missed;
        logic                        log_req;
    } t_work;

    typedef struct packed {
        logic [CNT_BITS-1:0]         run_count;
        logic [CNT_BITS-1:0]         miss_count;
        logic [SUM_BITS-1:0]         latency_sum;
        logic [TIME_BITS-1:0]        min_latency;
        logic [TIME_BITS-1:0]        max_latency;
        logic [TIME_BITS-1:0]        peak_exec;
        logic [TIME_BITS-1:0]        peak_total;
        logic signed [SUM_BITS-1:0]  busy_sum;
    } t_stats;

    typedef struct packed {
        t_stats                      stats;
        logic                        missed;
        logic                        log_req;
    } t_result;

    localparam t_stats STATS_RESET = '{
        run_count:   '0,
        miss_count:  '0,
        latency_sum: '0,
        min_latency: '1,
        max_latency: '0,
        peak_exec:   '0,
        peak_total:  '0,
        busy_sum:    '0
    };

endpackage

// ----- rtl/tts_front.sv -----
// Front end: deadline registers, timestamp differences and miss classification.
module tts_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [tts_pkg::TASK_BITS-1:0] i_task_id,
    input  logic [tts_pkg::TIME_BITS-1:0] i_event_time,
    input  logic [tts_pkg::TIME_BITS-1:0] i_start_time,
    input  logic [tts_pkg::TIME_BITS-1:0] i_end_time,
    input  logic                         i_always_log,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tts_pkg::TASK_BITS-1:0] i_cfg_index,
    input  logic [tts_pkg::DL_BITS-1:0]   i_cfg_data,
    input  logic                         i_full,
    output logic                         o_push,
    output tts_pkg::t_work               o_work
);
    import tts_pkg::*;

    logic [DL_BITS-1:0]        r_deadline [NUM_TASKS];
    logic                      w_task_ok;
    logic [DL_BITS-1:0]        w_deadline;
    logic signed [TIME_BITS:0] w_lat_diff;
    logic signed [TIME_BITS:0] w_exec;
    logic signed [TIME_BITS:0] w_total;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_full;
    assign w_task_ok   = i_task_id < TASK_BITS'(NUM_TASKS);
    // drop words for tasks that do not exist
    assign o_push      = i_in_valid && !i_full && w_task_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TASKS; k++) begin
                r_deadline[k] <= DEADLINE_RESET[k];
            end
        end else if (i_cfg_valid && (i_cfg_index < TASK_BITS'(NUM_TASKS))) begin
            r_deadline[i_cfg_index] <= i_cfg_data;
        end
    end

    always_comb begin
        w_deadline = w_task_ok ? r_deadline[i_task_id] : '0;
        w_lat_diff = $signed({1'b0, i_start_time}) - $signed({1'b0, i_event_time});
        w_exec     = $signed({1'b0, i_end_time}) - $signed({1'b0, i_start_time});
        w_total    = $signed({1'b0, i_end_time}) - $signed({1'b0, i_event_time});

        o_work.task_id    = i_task_id;
        // clamp at zero when start precedes release
        o_work.latency    = w_lat_diff[TIME_BITS] ? '0 : w_lat_diff[TIME_BITS-1:0];
        o_work.exec_time  = w_exec;
        o_work.total_time = w_total;
        o_work.missed     = !w_total[TIME_BITS] &&
                            (w_total[TIME_BITS-1:0] > TIME_BITS'(w_deadline));
        o_work.log_req    = i_always_log || o_work.missed;
    end

endmodule

// ----- rtl/tts_queue.sv -----
// Short queue of classified words between front end and update stage.
module tts_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tts_pkg::t_work i_data,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output tts_pkg::t_work o_data
);
    import tts_pkg::*;

    t_work                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;

    assign o_full  = r_count == QCNT_BITS'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
`endif

endmodule

// ----- rtl/tts_back.sv -----
// Update stage: per-task statistics entries and the output register.
module tts_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  tts_pkg::t_work   i_work,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output tts_pkg::t_result o_result
);
    import tts_pkg::*;

    t_stats  r_stats [NUM_TASKS];
    t_result r_result;
    logic    r_out_valid;
    logic    n_out_valid;
    t_stats  w_cur;
    t_stats  w_upd;
    logic    w_take;

    assign w_take      = i_valid && (!r_out_valid || !i_out_stall);
    assign o_pop       = w_take;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        w_cur = r_stats[i_work.task_id];
        w_upd = w_cur;
        w_upd.run_count   = w_cur.run_count + 1'b1;
        w_upd.miss_count  = w_cur.miss_count + CNT_BITS'(i_work.missed);
        w_upd.latency_sum = w_cur.latency_sum +
                            {{(SUM_BITS - TIME_BITS){1'b0}}, i_work.latency};
        if (i_work.latency < w_cur.min_latency) begin
            w_upd.min_latency = i_work.latency;
        end
        if (i_work.latency > w_cur.max_latency) begin
            w_upd.max_latency = i_work.latency;
        end
        // negative times never raise the maxima
        if (!i_work.exec_time[TIME_BITS] &&
            (i_work.exec_time[TIME_BITS-1:0] > w_cur.peak_exec)) begin
            w_upd.peak_exec = i_work.exec_time[TIME_BITS-1:0];
        end
        if (!i_work.total_time[TIME_BITS] &&
            (i_work.total_time[TIME_BITS-1:0] > w_cur.peak_total)) begin
            w_upd.peak_total = i_work.total_time[TIME_BITS-1:0];
        end
        w_upd.busy_sum = w_cur.busy_sum +
            $signed({{(SUM_BITS - TIME_BITS - 1){i_work.exec_time[TIME_BITS]}},
                     i_work.exec_time});
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_TASKS; k++) begin
                r_stats[k] <= STATS_RESET;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_stats[i_work.task_id] <= w_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result.stats   <= w_upd;
            r_result.missed  <= i_work.missed;
            r_result.log_req <= i_work.log_req;
        end
    end

`ifndef SYNTH
    a_take_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_out_valid)
        else $error("taken word not presented");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_result.stats.run_count == $past(w_cur.run_count) + 1'b1)
        else $error("run count did not advance by one");
    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> r_result.stats.min_latency <= r_result.stats.max_latency)
        else $error("latency minimum above maximum");
`endif

endmodule

// ----- rtl/task_timing_statistics_unit.sv -----
// Top level of the task timing statistics unit.
// Five-task timing monitor: each input word (task, release, start and end timestamps,
// log flag) updates that task's statistics entry, and the updated entry comes out as one
// result word with the miss and log flags. Words for task numbers 5 to 7 are accepted and
// dropped without a result. The block takes one word per cycle unless the input stalls;
// a result is presented after its word passes the two-entry queue behind the front end
// (written at the accepting edge) and the output register of the update stage, and one
// result leaves per cycle unless the output stalls. Then two more words fit in the
// queue before the input stalls. Deadline registers are written through the config
// port with no wait; the user must do so only while no words are in flight (unchecked).
module task_timing_statistics_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [tts_pkg::TASK_BITS-1:0]       i_task_id,
    input  logic [tts_pkg::TIME_BITS-1:0]       i_event_time,
    input  logic [tts_pkg::TIME_BITS-1:0]       i_start_time,
    input  logic [tts_pkg::TIME_BITS-1:0]       i_end_time,
    input  logic                                i_always_log,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tts_pkg::TASK_BITS-1:0]       i_cfg_index,
    input  logic [tts_pkg::DL_BITS-1:0]         i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [tts_pkg::CNT_BITS-1:0]        o_run_count,
    output logic [tts_pkg::CNT_BITS-1:0]        o_miss_count,
    output logic [tts_pkg::SUM_BITS-1:0]        o_latency_sum,
    output logic [tts_pkg::TIME_BITS-1:0]       o_min_latency,
    output logic [tts_pkg::TIME_BITS-1:0]       o_max_latency,
    output logic [tts_pkg::TIME_BITS-1:0]       o_peak_exec,
    output logic [tts_pkg::TIME_BITS-1:0]       o_peak_total,
    output logic signed [tts_pkg::SUM_BITS-1:0] o_busy_sum,
    output logic                                o_deadline_missed,
    output logic                                o_log_request
);
    import tts_pkg::*;

    t_work   w_push_data;
    t_work   w_pop_data;
    t_result w_result;
    logic    w_push;
    logic    w_full;
    logic    w_q_valid;
    logic    w_pop;

    tts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_task_id    (i_task_id),
        .i_event_time (i_event_time),
        .i_start_time (i_start_time),
        .i_end_time   (i_end_time),
        .i_always_log (i_always_log),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_work       (w_push_data)
    );

    tts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_data  (w_pop_data)
    );

    tts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_work      (w_pop_data),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (w_result)
    );

    assign o_run_count       = w_result.stats.run_count;
    assign o_miss_count      = w_result.stats.miss_count;
    assign o_latency_sum     = w_result.stats.latency_sum;
    assign o_min_latency     = w_result.stats.min_latency;
    assign o_max_latency     = w_result.stats.max_latency;
    assign o_peak_exec       = w_result.stats.peak_exec;
    assign o_peak_total      = w_result.stats.peak_total;
    assign o_busy_sum        = w_result.stats.busy_sum;
    assign o_deadline_missed = w_result.missed;
    assign o_log_request     = w_result.log_req;

endmodule

// ----- sim/tb_task_timing_statistics_unit.sv -----
// Self-checking testbench for the task timing statistics unit: directed and random words.
`timescale 1ns / 1ps

module tb_task_timing_statistics_unit;
    import tts_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 6;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [TASK_BITS-1:0] i_task_id = '0;
    logic [TIME_BITS-1:0] i_event_time = '0;
    logic [TIME_BITS-1:0] i_start_time = '0;
    logic [TIME_BITS-1:0] i_end_time = '0;
    logic i_always_log = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [TASK_BITS-1:0] i_cfg_index = '0;
    logic [DL_BITS-1:0] i_cfg_data = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [CNT_BITS-1:0] o_run_count;
    logic [CNT_BITS-1:0] o_miss_count;
    logic [SUM_BITS-1:0] o_latency_sum;
    logic [TIME_BITS-1:0] o_min_latency;
    logic [TIME_BITS-1:0] o_max_latency;
    logic [TIME_BITS-1:0] o_peak_exec;
    logic [TIME_BITS-1:0] o_peak_total;
    logic signed [SUM_BITS-1:0] o_busy_sum;
    logic o_deadline_missed;
    logic o_log_request;

    // predicted per-task state and deadlines
    t_stats task_stats [NUM_TASKS];
    logic [NUM_TASKS-1:0][DL_BITS-1:0] tb_deadline;
    t_result stats_due [$];
    int mismatches = 0;
    int unsigned cycle_count = 0;
    bit calm = 1'b0;

    task_timing_statistics_unit DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_task_id(i_task_id),
        .i_event_time(i_event_time),
        .i_start_time(i_start_time),
        .i_end_time(i_end_time),
        .i_always_log(i_always_log),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_run_count(o_run_count),
        .o_miss_count(o_miss_count),
        .o_latency_sum(o_latency_sum),
        .o_min_latency(o_min_latency),
        .o_max_latency(o_max_latency),
        .o_peak_exec(o_peak_exec),
        .o_peak_total(o_peak_total),
        .o_busy_sum(o_busy_sum),
        .o_deadline_missed(o_deadline_missed),
        .o_log_request(o_log_request)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_task_timing_statistics_unit failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 11);
    end

    function automatic logic [TIME_BITS-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_BITS-1:0];
    endfunction

    // Apply one word to the predicted entry of its task and return the updated entry.
    function automatic t_result update_task_stats(input logic [TASK_BITS-1:0] tid,
                                                  input logic [TIME_BITS-1:0] evt, st, fin,
                                                  input logic alog);
        longint evt_t, st_t, fin_t, exec_t, total_t, limit_t;
        logic [TIME_BITS-1:0] lat;
        logic miss;
        t_stats entry;
        t_result res;
        evt_t = longint'({16'd0, evt});
        st_t = longint'({16'd0, st});
        fin_t = longint'({16'd0, fin});
        limit_t = longint'({40'd0, tb_deadline[tid]});
        lat = (st_t > evt_t) ? TIME_BITS'(st_t - evt_t) : '0;
        exec_t = fin_t - st_t;
        total_t = fin_t - evt_t;
        miss = total_t > limit_t;
        entry = task_stats[tid];
        entry.run_count += 32'd1;
        if (miss) begin
            entry.miss_count += 32'd1;
        end
        entry.latency_sum += {16'd0, lat};
        if (lat < entry.min_latency) begin
            entry.min_latency = lat;
        end
        if (lat > entry.max_latency) begin
            entry.max_latency = lat;
        end
        // negative times never raise the maxima
        if (exec_t > longint'({16'd0, entry.peak_exec})) begin
            entry.peak_exec = exec_t[TIME_BITS-1:0];
        end
        if (total_t > longint'({16'd0, entry.peak_total})) begin
            entry.peak_total = total_t[TIME_BITS-1:0];
        end
        entry.busy_sum += exec_t;
        task_stats[tid] = entry;
        res.stats = entry;
        res.missed = miss;
        res.log_req = alog | miss;
        return res;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want, got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (stats_due.size() == 0) begin
                $display("%0t: result word with none outstanding, expected none actual %h",
                         $time, o_run_count);
                mismatches++;
            end else begin
                want = stats_due.pop_front();
                check_field("run_count", want.stats.run_count, o_run_count);
                check_field("miss_count", want.stats.miss_count, o_miss_count);
                check_field("latency_sum", want.stats.latency_sum, o_latency_sum);
                check_field("min_latency", want.stats.min_latency, o_min_latency);
                check_field("max_latency", want.stats.max_latency, o_max_latency);
                check_field("peak_exec", want.stats.peak_exec, o_peak_exec);
                check_field("peak_total", want.stats.peak_total, o_peak_total);
                check_field("busy_sum", want.stats.busy_sum, o_busy_sum);
                check_field("deadline_missed", want.missed, o_deadline_missed);
                check_field("log_request", want.log_req, o_log_request);
            end
        end
    end

    task automatic send_word(input logic [TASK_BITS-1:0] tid,
                             input logic [TIME_BITS-1:0] evt, st, fin,
                             input logic alog);
        while (!calm && $urandom_range(99) < 11) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_task_id <= tid;
        i_event_time <= evt;
        i_start_time <= st;
        i_end_time <= fin;
        i_always_log <= alog;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        if (tid < NUM_TASKS) begin
            stats_due.push_back(update_task_stats(tid, evt, st, fin, alog));
        end
    endtask

    task automatic wait_results_settled();
        i_in_valid <= 1'b0;
        while (stats_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Write all five deadlines, then one junk write to an unused index.
    task automatic set_deadlines(input logic [NUM_TASKS-1:0][DL_BITS-1:0] dl);
        int k;
        // let the pipeline settle before writing the deadlines
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        for (k = 0; k <= NUM_TASKS; k++) begin
            i_cfg_valid <= 1'b1;
            if (k < NUM_TASKS) begin
                i_cfg_index <= TASK_BITS'(k);
                i_cfg_data <= dl[k];
            end else begin
                i_cfg_index <= TASK_BITS'($urandom_range(7, NUM_TASKS));
                i_cfg_data <= DL_BITS'($urandom);
            end
            @(posedge i_clk);
            while (!o_cfg_ready) begin
                @(posedge i_clk);
            end
            if (k < NUM_TASKS) begin
                tb_deadline[k] = dl[k];
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_deadlines();
        send_word(0, 0, 0, 0, 0);
        send_word(0, 100, 100, 5100, 0);                    // total equals deadline
        send_word(0, 100, 200, 5101, 0);                    // one past deadline
        send_word(1, 1000, 500, 11000, 1);                  // start before release
        send_word(1, 0, '1, '1, 0);                         // largest latency
        send_word(2, 10, 1000, 500, 0);                     // end before start
        send_word(2, 2000, 3000, 1000, 1);                  // end before release
        send_word(3, '1, 0, 0, 0);
        send_word(3, 0, 0, '1, 0);
        send_word(4, 48'h5555_5555_5555, 48'h5555_5555_6000, 48'h5555_5556_0000, 1);
        send_word(4, 48'hAAAA_AAAA_AAAA, 48'hAAAA_AAAA_AAAB, 48'hAAAA_AAAA_BBBB, 0);
        send_word(5, '1, '1, '1, 1);                        // out-of-range tasks: dropped
        send_word(6, 0, '1, 0, 0);
        send_word(7, '1, 0, '1, 1);
        send_word(4, 0, 0, 0, 0);
    endtask

    task automatic test_deadline_extremes();
        int k;
        wait_results_settled();
        set_deadlines('0);
        for (k = 0; k < NUM_TASKS; k++) begin
            send_word(TASK_BITS'(k), 100, 100, 48'(100 + k % 2), 1'(k % 2));
        end
        wait_results_settled();
        set_deadlines({NUM_TASKS{24'hFF_FFFF}});
        for (k = 0; k < NUM_TASKS; k++) begin
            send_word(TASK_BITS'(k), 0, 5, 48'(24'hFF_FFFF + k % 2), 0);
        end
    endtask

    task automatic test_random_traffic();
        logic [NUM_TASKS-1:0][DL_BITS-1:0] dl;
        logic [TASK_BITS-1:0] tid;
        logic [TIME_BITS-1:0] evt, st, fin;
        logic [DL_BITS-1:0] limit;
        logic alog;
        int phase, k, roll, sent;
        for (phase = 0; phase < 4; phase++) begin
            for (k = 0; k < NUM_TASKS; k++) begin
                case (phase)
                    1: dl[k] = DL_BITS'($urandom);
                    2: dl[k] = ($urandom_range(1) == 1) ? 24'hFF_FFFF : 24'd0;
                    default: dl[k] = DL_BITS'($urandom_range(20000));
                endcase
            end
            // hold off until the pipe is empty before reprogramming
            wait_results_settled();
            set_deadlines(dl);
            calm = (phase == 1);
            sent = 0;
            while (sent < 195) begin
                roll = $urandom_range(99);
                tid = ($urandom_range(99) < 6) ? TASK_BITS'($urandom_range(7, NUM_TASKS))
                                               : TASK_BITS'($urandom_range(NUM_TASKS - 1));
                limit = (tid < NUM_TASKS) ? tb_deadline[tid] : '0;
                alog = 1'($urandom_range(1));
                evt = ($urandom_range(3) == 0) ? rand48() : 48'($urandom_range(1000000));
                if (roll < 70) begin
                    st = evt + 48'($urandom_range(3000));
                    fin = st + 48'($urandom_range(20000));
                end else if (roll < 80) begin
                    st = evt - 48'($urandom_range(3000));
                    fin = st - 48'($urandom_range(2000)) + 48'($urandom_range(2000));
                end else if (roll < 94) begin
                    evt = rand48();
                    st = rand48();
                    fin = rand48();
                end else begin
                    // land right on the deadline boundary
                    st = evt + 48'($urandom_range(50));
                    fin = evt + {24'd0, limit} - 48'd1 + 48'($urandom_range(2));
                end
                send_word(tid, evt, st, fin, alog);
                if (tid < NUM_TASKS) begin
                    sent++;
                end
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        int k;
        tb_deadline = DEADLINE_RESET;
        for (k = 0; k < NUM_TASKS; k++) begin
            task_stats[k] = STATS_RESET;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_deadlines();
        test_deadline_extremes();
        test_random_traffic();
        wait_results_settled();
        repeat (SETTLE_CYCLES + 2) @(posedge i_clk);
        if (mismatches == 0 && stats_due.size() == 0) begin
            $display("tb_task_timing_statistics_unit passed");
        end else begin
            $display("tb_task_timing_statistics_unit failed");
        end
        $finish;
    end

endmodule
